// ===== hdl/lph_pkg.sv =====
// ----------------------------------------------------------------------------
// lph_pkg
// Types and constants shared by the linear probing hash table modules.
// ----------------------------------------------------------------------------
package lph_pkg;

  localparam int MODE_W   = 2;
  localparam int KEY_W    = 31;
  localparam int VALUE_W  = 64;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_SEARCH = 2'd1,
    MODE_DELETE = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    SLOT_EMPTY   = 2'd0,
    SLOT_USED    = 2'd1,
    SLOT_DELETED = 2'd2
  } slot_st_t;

  typedef enum logic [STATUS_W-1:0] {
    RES_OK        = 2'd0,
    RES_NOT_FOUND = 2'd1,
    RES_FULL      = 2'd2
  } res_code_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_PROBE,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    slot_st_t            status;
    logic [KEY_W-1:0]    key;
    logic [VALUE_W-1:0]  value;
  } entry_t;

  typedef struct packed {
    res_code_t           status;
    logic [SLOT_W-1:0]   slot;
    logic [VALUE_W-1:0]  found_value;
  } result_t;

  typedef struct packed {
    logic                start;
    logic [KEY_W-1:0]    key;
  } mod_req_t;

endpackage

// ===== hdl/lph_if.sv =====
// ----------------------------------------------------------------------------
// lph_in_if / lph_out_if
// Valid/ready channels for operation words and result words.
// ----------------------------------------------------------------------------
interface lph_in_if;
  logic                         valid;
  logic                         ready;
  logic [lph_pkg::MODE_W-1:0]   mode;
  logic [lph_pkg::KEY_W-1:0]    key;
  logic [lph_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output mode, output key, output value, input ready);
  modport sink (input valid, input mode, input key, input value, output ready);
endinterface

interface lph_out_if;
  logic                          valid;
  logic                          ready;
  logic [lph_pkg::STATUS_W-1:0]  status;
  logic [lph_pkg::SLOT_W-1:0]    slot;
  logic [lph_pkg::VALUE_W-1:0]   found_value;

  modport source (output valid, output status, output slot, output found_value,
                  input ready);
  modport sink (input valid, input status, input slot, input found_value,
                output ready);
endinterface

// ===== hdl/lph_mod.sv =====
// ----------------------------------------------------------------------------
// lph_mod
// Home slot unit: key modulo SLOTS by pipelined reciprocal multiplication,
// through the product, partial remainder and remainder registers.
// ----------------------------------------------------------------------------
module lph_mod #(
  parameter int SLOTS = 32,
  parameter int AW    = $clog2(SLOTS)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lph_pkg::mod_req_t   req,
  output logic                done,
  output logic [AW-1:0]       rem
);

  localparam int          SHIFT    = lph_pkg::KEY_W + AW;
  localparam int          PROD_W   = 2 * lph_pkg::KEY_W + 1;
  localparam logic [63:0] RECIP_64 = (64'd1 << SHIFT) / 64'(SLOTS);
  // The reciprocal floor(2^SHIFT / SLOTS) always fits in KEY_W + 1 bits.
  localparam logic [lph_pkg::KEY_W:0] RECIP   = RECIP_64[lph_pkg::KEY_W:0];
  localparam logic [AW:0]             SLOTS_C = (AW + 1)'(SLOTS);

  logic [lph_pkg::KEY_W-1:0] key_r;
  logic [PROD_W-1:0]         prod_r;
  logic [PROD_W-1:0]         prod_nxt;
  logic [AW:0]               part_r;
  logic [AW:0]               part_nxt;
  logic [AW-1:0]             rem_r;
  logic [AW-1:0]             rem_nxt;
  logic [2:0]                stage_r;
  logic                      done_r;

  // The estimated quotient is low by at most one, so the partial remainder
  // lies below 2 * SLOTS and only its low AW + 1 bits are needed.
  always_comb begin
    logic [AW:0] quo_lo;
    logic [AW:0] back_lo;
    prod_nxt = PROD_W'(key_r) * PROD_W'(RECIP);
    quo_lo   = (AW + 1)'(prod_r >> SHIFT);
    back_lo  = (AW + 1)'(quo_lo * SLOTS_C);
    part_nxt = key_r[AW:0] - back_lo;
    rem_nxt  = (part_r >= SLOTS_C) ? AW'(part_r - SLOTS_C) : part_r[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= '0;
      done_r  <= 1'b0;
    end else begin
      stage_r <= {stage_r[1:0], req.start};
      done_r  <= stage_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      key_r <= req.key;
    end
    prod_r <= prod_nxt;
    part_r <= part_nxt;
    if (stage_r[2]) begin
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ===== hdl/lph_mem.sv =====
// ----------------------------------------------------------------------------
// lph_mem
// Slot table: one write port and one registered read port.
// ----------------------------------------------------------------------------
module lph_mem #(
  parameter int SLOTS = 32,
  parameter int AW    = $clog2(SLOTS)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  lph_pkg::entry_t   wdata,
  input  logic [AW-1:0]     raddr,
  output lph_pkg::entry_t   rdata
);

  lph_pkg::entry_t mem [SLOTS];
  lph_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/lph_ctrl.sv =====
// ----------------------------------------------------------------------------
// lph_ctrl
// Probe sequencer: clears the table, walks the probe chain one slot a cycle,
// updates the hit slot and holds the result word until it is taken.
// ----------------------------------------------------------------------------
module lph_ctrl #(
  parameter int SLOTS = 32,
  parameter int AW    = $clog2(SLOTS)
) (
  input  logic               clk,
  input  logic               rst_n,
  lph_in_if.sink             in_chan,
  lph_out_if.source          out_chan,
  output lph_pkg::mod_req_t  mod_req,
  input  logic               mod_done,
  input  logic [AW-1:0]      mod_rem,
  output logic               mem_we,
  output logic [AW-1:0]      mem_waddr,
  output lph_pkg::entry_t    mem_wdata,
  output logic [AW-1:0]      mem_raddr,
  input  lph_pkg::entry_t    mem_rdata
);

  localparam int          SW   = lph_pkg::SLOT_W;
  localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

  lph_pkg::ctrl_state_t state_r, state_nxt;
  logic [AW-1:0]        idx_r, idx_nxt;
  logic [AW-1:0]        cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  lph_pkg::result_t     out_res_r, out_res_nxt;
  lph_pkg::result_t     res_r, res_nxt;
  lph_pkg::mode_t       mode_r, mode_nxt;
  logic [lph_pkg::KEY_W-1:0]   key_r, key_nxt;
  logic [lph_pkg::VALUE_W-1:0] value_r, value_nxt;
  logic [AW-1:0]        idx_inc;

  assign idx_inc = (idx_r == LAST) ? '0 : idx_r + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    mode_nxt      = mode_r;
    key_nxt       = key_r;
    value_nxt     = value_r;
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    in_chan.ready = 1'b0;
    mod_req.start = 1'b0;
    mod_req.key   = in_chan.key;
    mem_we        = 1'b0;
    mem_waddr     = idx_r;
    mem_wdata     = '{status: lph_pkg::SLOT_EMPTY, key: '0, value: '0};
    // Reads run one slot ahead so that a probe completes every cycle.
    mem_raddr     = idx_inc;

    unique case (state_r)
      lph_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          state_nxt = lph_pkg::ST_IDLE;
        end
      end

      lph_pkg::ST_IDLE: begin
        in_chan.ready = 1'b1;
        if (in_chan.valid) begin
          mode_nxt  = lph_pkg::mode_t'(in_chan.mode);
          key_nxt   = in_chan.key;
          value_nxt = in_chan.value;
          unique case (lph_pkg::mode_t'(in_chan.mode))
            lph_pkg::MODE_INSERT, lph_pkg::MODE_SEARCH, lph_pkg::MODE_DELETE: begin
              mod_req.start = 1'b1;
              state_nxt     = lph_pkg::ST_HASH;
            end
            default: begin
              res_nxt   = '{status: lph_pkg::RES_NOT_FOUND, slot: '0, found_value: '0};
              state_nxt = lph_pkg::ST_DONE;
            end
          endcase
        end
      end

      lph_pkg::ST_HASH: begin
        mem_raddr = mod_rem;
        if (mod_done) begin
          idx_nxt   = mod_rem;
          cnt_nxt   = '0;
          state_nxt = lph_pkg::ST_PROBE;
        end
      end

      lph_pkg::ST_PROBE: begin
        idx_nxt = idx_inc;
        cnt_nxt = cnt_r + 1'b1;
        if (mode_r == lph_pkg::MODE_INSERT) begin
          if (mem_rdata.status != lph_pkg::SLOT_USED) begin
            mem_we    = 1'b1;
            mem_wdata = '{status: lph_pkg::SLOT_USED, key: key_r, value: value_r};
            res_nxt   = '{status: lph_pkg::RES_OK, slot: SW'(idx_r), found_value: '0};
            state_nxt = lph_pkg::ST_DONE;
          end else if (cnt_r == LAST) begin
            res_nxt   = '{status: lph_pkg::RES_FULL, slot: '0, found_value: '0};
            state_nxt = lph_pkg::ST_DONE;
          end
        end else begin
          priority if (mem_rdata.status == lph_pkg::SLOT_EMPTY) begin
            res_nxt   = '{status: lph_pkg::RES_NOT_FOUND, slot: '0, found_value: '0};
            state_nxt = lph_pkg::ST_DONE;
          end else if (mem_rdata.status == lph_pkg::SLOT_USED && mem_rdata.key == key_r) begin
            if (mode_r == lph_pkg::MODE_DELETE) begin
              mem_we    = 1'b1;
              mem_wdata = '{status: lph_pkg::SLOT_DELETED, key: mem_rdata.key,
                            value: mem_rdata.value};
            end
            res_nxt   = '{status: lph_pkg::RES_OK, slot: SW'(idx_r),
                          found_value: mem_rdata.value};
            state_nxt = lph_pkg::ST_DONE;
          end else if (cnt_r == LAST) begin
            res_nxt   = '{status: lph_pkg::RES_NOT_FOUND, slot: '0, found_value: '0};
            state_nxt = lph_pkg::ST_DONE;
          end else begin
          end
        end
      end

      lph_pkg::ST_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          state_nxt     = lph_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = lph_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lph_pkg::ST_CLEAR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    res_r     <= res_nxt;
    mode_r    <= mode_nxt;
    key_r     <= key_nxt;
    value_r   <= value_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_res_r.status;
  assign out_chan.slot        = out_res_r.slot;
  assign out_chan.found_value = out_res_r.found_value;

  // The table is only written by the clearing pass or at the end of a probe.
  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == lph_pkg::ST_CLEAR || state_r == lph_pkg::ST_PROBE))
    else $error("table written outside clearing or probing");

  // The home slot unit only finishes while the sequencer waits for it.
  a_hash_done: assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> state_r == lph_pkg::ST_HASH)
    else $error("home slot result arrived outside hashing");

  // A failed operation reports slot zero and a zero payload.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.status != lph_pkg::RES_OK) |->
      (out_res_r.slot == '0 && out_res_r.found_value == '0))
    else $error("failure result carries a slot or payload");

  // A finished result reaches the output register once it is free.
  a_deliver: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lph_pkg::ST_DONE && (!out_valid_r || out_chan.ready)) |=>
      (out_valid_r && state_r == lph_pkg::ST_IDLE))
    else $error("result not delivered to output register");

endmodule

// ===== hdl/linear_probe_hash_table.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing hash table with linear probing and deletion markers.
// ----------------------------------------------------------------------------
// Each input word is an insert, search or delete on a table of SLOTS slots,
// and each produces exactly one result word. After reset the block clears
// the table before it accepts its first word. The home slot unit reduces the
// key modulo SLOTS by a reciprocal multiplication, and the probe walk then
// reads one slot a cycle from the table memory. An unused mode answers
// "not found". A new word is accepted while the last result still waits in
// the output register, and a finished operation waits until that register
// is free.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
  parameter int SLOTS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  lph_in_if.sink     in_chan,
  lph_out_if.source  out_chan
);

  localparam int AW = $clog2(SLOTS);

  lph_pkg::mod_req_t mod_req;
  logic              mod_done;
  logic [AW-1:0]     mod_rem;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [AW-1:0]     mem_raddr;
  lph_pkg::entry_t   mem_wdata;
  lph_pkg::entry_t   mem_rdata;

  lph_mod #(.SLOTS(SLOTS), .AW(AW)) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  lph_mem #(.SLOTS(SLOTS), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  lph_ctrl #(.SLOTS(SLOTS), .AW(AW)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .mod_req   (mod_req),
    .mod_done  (mod_done),
    .mod_rem   (mod_rem),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

endmodule
